// ===== src/rfr_pkg.sv =====
// rfr_pkg: shared types and constants of the radar frame receiver
// used by rfr_parse and radar_frame_receiver_core; no dependencies
`default_nettype none

package rfr_pkg;

    localparam logic [7:0]  HDR_BYTE   = 8'h51;
    localparam logic [7:0]  BASE_LEN   = 8'd6;
    localparam logic [15:0] ANY_DEVICE = 16'h0000;
    localparam logic [7:0]  LEAD_BYTES = 8'd3;

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_ID_HI  = 8'b0000_0010,
        PH_ID_LO  = 8'b0000_0100,
        PH_LEN    = 8'b0000_1000,
        PH_FORMAT = 8'b0001_0000,
        PH_FUNC   = 8'b0010_0000,
        PH_DATA   = 8'b0100_0000,
        PH_CHECK  = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_CHECKSUM  = 2'd1,
        ST_OTHER_DEV = 2'd2,
        ST_MALFORMED = 2'd3
    } status_t;

    typedef struct packed {
        status_t     frame_status;
        logic [7:0]  function_code;
        logic [15:0] frame_device;
        logic [7:0]  data_count;
        logic [23:0] lead_bytes;
        logic [31:0] data_value;
    } result_t;

endpackage

`default_nettype wire

// ===== src/radar_frame_receiver_core.sv =====
// radar_frame_receiver_core: top level with input word register, result register
// and device filter register; depends on rfr_pkg and rfr_parse
`default_nettype none

// Deframer for a serial byte stream: hunts for header 0x51, reads device id,
// length, format and function, then length-6 data bytes and an additive
// checksum, and delivers one result word per frame (or at once for a length
// below 6). One byte is taken per clock when the result side keeps up; a
// received word is held in the input register, and its result is loaded from
// there into the result register when the word is processed and the result
// slot is free. The byte rate is set by the frame state machine, which
// updates once for every processed byte. The device filter is written
// through the cfg channel, which is always ready; write it while no frame is in
// progress.
module radar_frame_receiver_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] device_filter,

    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       frame_status,
    output logic [7:0]       function_code,
    output logic [15:0]      frame_device,
    output logic [7:0]       data_count,
    output logic [23:0]      lead_bytes,
    output logic [31:0]      data_value
);
    import rfr_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    logic [15:0] filter_reg;

    logic        emit;
    result_t     result;
    logic        out_free;
    logic        step;
    logic        rx_take;

    rfr_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .rx_byte       (in_byte_reg),
        .device_filter (filter_reg),
        .emit          (emit),
        .result        (result)
    );

    // a held word moves on unless it makes a result and the result slot is blocked
    assign out_free = !out_valid_reg || !res_stall;
    assign step     = in_valid_reg && (!emit || out_free);
    assign rx_stall = in_valid_reg && !step;
    assign rx_take  = rx_valid && !rx_stall;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (rx_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (step && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filter_reg    <= ANY_DEVICE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                filter_reg <= device_filter;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && emit)
        begin
            out_reg <= result;
        end
    end

    assign res_valid     = out_valid_reg;
    assign frame_status  = out_reg.frame_status;
    assign function_code = out_reg.function_code;
    assign frame_device  = out_reg.frame_device;
    assign data_count    = out_reg.data_count;
    assign lead_bytes    = out_reg.lead_bytes;
    assign data_value    = out_reg.data_value;

`ifndef SYNTHESIS
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_stall) |-> !(step && emit))
        else $error("pending result overwritten");

    a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && frame_status == ST_MALFORMED) |->
        (function_code == 8'd0 && data_count == 8'd0 && lead_bytes == 24'd0
         && data_value == 32'd0))
        else $error("malformed frame result carries data");

    a_empty_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && data_count == 8'd0) |-> (lead_bytes == 24'd0 && data_value == 32'd0))
        else $error("frame without data reports data bytes");

    a_result_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step && emit))
        else $error("result appeared without a processed word");
`endif

endmodule

`default_nettype wire

// ===== src/rfr_parse.sv =====
// rfr_parse: frame state machine, checksum and field capture, one byte per step
// depends on rfr_pkg
`default_nettype none

module rfr_parse (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [7:0]     rx_byte,
    input  wire logic [15:0]    device_filter,
    output logic                emit,
    output rfr_pkg::result_t    result
);
    import rfr_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  data_left_reg, data_left_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [15:0] device_reg,   device_next;
    logic [7:0]  length_reg,   length_next;
    logic [7:0]  function_reg, function_next;
    logic [23:0] lead_reg,     lead_next;
    logic [31:0] value_reg,    value_next;

    logic [7:0]  count;
    logic [7:0]  pos;
    logic [7:0]  sum_add;

    assign count   = length_reg - BASE_LEN;
    assign pos     = count - data_left_reg;
    assign sum_add = sum_reg + rx_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        data_left_next = data_left_reg;
        sum_next      = sum_reg;
        device_next   = device_reg;
        length_next   = length_reg;
        function_next = function_reg;
        lead_next     = lead_reg;
        value_next    = value_reg;
        emit          = 1'b0;

        result.frame_status  = ST_ACCEPTED;
        result.function_code = function_reg;
        result.frame_device  = device_reg;
        result.data_count    = count;
        result.lead_bytes    = lead_reg;
        result.data_value    = value_reg;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    // a new frame starts from a clean slate
                    phase_next     = PH_ID_HI;
                    data_left_next = '0;
                    sum_next       = rx_byte;
                    device_next    = '0;
                    length_next    = '0;
                    function_next  = '0;
                    lead_next      = '0;
                    value_next     = '0;
                end
            end
            PH_ID_HI:
            begin
                device_next = {rx_byte, 8'h00};
                sum_next    = sum_add;
                phase_next  = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                device_next = {device_reg[15:8], rx_byte};
                sum_next    = sum_add;
                phase_next  = PH_LEN;
            end
            PH_LEN:
            begin
                if (rx_byte < BASE_LEN)
                begin
                    emit                 = 1'b1;
                    result.frame_status  = ST_MALFORMED;
                    result.function_code = '0;
                    result.data_count    = '0;
                    result.lead_bytes    = '0;
                    result.data_value    = '0;
                    phase_next           = PH_HUNT;
                end
                else
                begin
                    length_next    = rx_byte;
                    data_left_next = rx_byte - BASE_LEN;
                    sum_next       = sum_add;
                    phase_next     = PH_FORMAT;
                end
            end
            PH_FORMAT:
            begin
                sum_next   = sum_add;
                phase_next = PH_FUNC;
            end
            PH_FUNC:
            begin
                function_next = rx_byte;
                sum_next      = sum_add;
                phase_next    = (data_left_reg == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                if (pos < LEAD_BYTES)
                begin
                    case (pos[1:0])
                        2'd0:    lead_next[23:16] = rx_byte;
                        2'd1:    lead_next[15:8]  = rx_byte;
                        2'd2:    lead_next[7:0]   = rx_byte;
                        default: lead_next        = lead_reg;
                    endcase
                end
                value_next     = {value_reg[23:0], rx_byte};
                sum_next       = sum_add;
                data_left_next = data_left_reg - 8'd1;
                if (data_left_reg == 8'd1)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                emit = 1'b1;
                // checksum error takes priority over the device filter
                if (rx_byte != sum_reg)
                begin
                    result.frame_status = ST_CHECKSUM;
                end
                else if (device_filter != ANY_DEVICE && device_reg != device_filter)
                begin
                    result.frame_status = ST_OTHER_DEV;
                end
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            data_left_reg <= '0;
            sum_reg       <= '0;
            device_reg    <= '0;
            length_reg    <= '0;
            function_reg  <= '0;
            lead_reg      <= '0;
            value_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            data_left_reg <= data_left_next;
            sum_reg       <= sum_next;
            device_reg    <= device_next;
            length_reg    <= length_next;
            function_reg  <= function_next;
            lead_reg      <= lead_next;
            value_reg     <= value_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_radar_frame_receiver_core.sv =====
// testbench for radar_frame_receiver_core: drives byte streams, predicts frame reports,
// checks every result word field by field; depends on rfr_pkg and the core rtl
`default_nettype none

module tb_radar_frame_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rfr_pkg::*;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        rx_valid      = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte       = 8'h00;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] device_filter = 16'h0000;
    logic        res_valid;
    logic        res_stall     = 1'b0;
    logic [1:0]  frame_status;
    logic [7:0]  function_code;
    logic [15:0] frame_device;
    logic [7:0]  data_count;
    logic [23:0] lead_bytes;
    logic [31:0] data_value;

    radar_frame_receiver_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .device_filter (device_filter),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .frame_status  (frame_status),
        .function_code (function_code),
        .frame_device  (frame_device),
        .data_count    (data_count),
        .lead_bytes    (lead_bytes),
        .data_value    (data_value)
    );

    // own copy of the deframer state
    phase_t      fr_phase;
    logic [7:0]  fr_left;
    logic [7:0]  fr_sum;
    logic [15:0] fr_device;
    logic [7:0]  fr_length;
    logic [7:0]  fr_function;
    logic [23:0] fr_lead;
    logic [31:0] fr_value;
    logic [15:0] filter_shadow = ANY_DEVICE;

    result_t frame_reports_due[$];

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int err_count  = 0;
    int items_used = 0;
    int status_seen[4];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    function automatic void clear_frame_state();
        fr_phase    = PH_HUNT;
        fr_left     = '0;
        fr_sum      = '0;
        fr_device   = '0;
        fr_length   = '0;
        fr_function = '0;
        fr_lead     = '0;
        fr_value    = '0;
    endfunction

    function automatic void track_rx_byte(input logic [7:0] b);
        result_t    r;
        logic [7:0] pos;
        r = '0;
        items_used++;
        case (fr_phase)
            PH_HUNT:
            begin
                if (b == HDR_BYTE)
                begin
                    clear_frame_state();
                    fr_sum   = b;
                    fr_phase = PH_ID_HI;
                end
            end
            PH_ID_HI:
            begin
                fr_device = {b, 8'h00};
                fr_sum    = fr_sum + b;
                fr_phase  = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                fr_device[7:0] = b;
                fr_sum         = fr_sum + b;
                fr_phase       = PH_LEN;
            end
            PH_LEN:
            begin
                if (b < BASE_LEN)
                begin
                    r.frame_status = ST_MALFORMED;
                    r.frame_device = fr_device;
                    frame_reports_due.insert(frame_reports_due.size(), r);
                    clear_frame_state();
                end
                else
                begin
                    fr_length = b;
                    fr_left   = b - BASE_LEN;
                    fr_sum    = fr_sum + b;
                    fr_phase  = PH_FORMAT;
                end
            end
            PH_FORMAT:
            begin
                fr_sum   = fr_sum + b;
                fr_phase = PH_FUNC;
            end
            PH_FUNC:
            begin
                fr_function = b;
                fr_sum      = fr_sum + b;
                fr_phase    = (fr_left == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                pos = (fr_length - BASE_LEN) - fr_left;
                case (pos)
                    8'd0: fr_lead[23:16] = b;
                    8'd1: fr_lead[15:8]  = b;
                    8'd2: fr_lead[7:0]   = b;
                    default: ;
                endcase
                fr_value = {fr_value[23:0], b};
                fr_sum   = fr_sum + b;
                fr_left  = fr_left - 8'd1;
                if (fr_left == 8'd0)
                    fr_phase = PH_CHECK;
            end
            default:
            begin
                if (b != fr_sum)
                    r.frame_status = ST_CHECKSUM;
                else if (filter_shadow != ANY_DEVICE && fr_device != filter_shadow)
                    r.frame_status = ST_OTHER_DEV;
                else
                    r.frame_status = ST_ACCEPTED;
                r.function_code = fr_function;
                r.frame_device  = fr_device;
                r.data_count    = fr_length - BASE_LEN;
                r.lead_bytes    = fr_lead;
                r.data_value    = fr_value;
                frame_reports_due.insert(frame_reports_due.size(), r);
                clear_frame_state();
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (frame_reports_due.size() == 0)
            begin
                $error("result word with no frame report pending");
                err_count++;
            end
            else
            begin
                want = frame_reports_due.pop_front();
                check_field("frame_status", 32'(want.frame_status), 32'(frame_status));
                check_field("function_code", 32'(want.function_code), 32'(function_code));
                check_field("frame_device", 32'(want.frame_device), 32'(frame_device));
                check_field("data_count", 32'(want.data_count), 32'(data_count));
                check_field("lead_bytes", 32'(want.lead_bytes), 32'(lead_bytes));
                check_field("data_value", want.data_value, data_value);
                status_seen[frame_status]++;
            end
        end
    end

    // result side back-pressure; a hold-off overrides the random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(255));
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        track_rx_byte(b);
    endtask

    // fill < 0 gives random data bytes, otherwise every data byte is fill
    task automatic send_frame(input logic [15:0] dev, input logic [7:0] len,
                              input logic [7:0] func, input int fill, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] fmt;
        logic [7:0] b;
        int         i;
        fmt = 8'($urandom_range(255));
        sum = HDR_BYTE + dev[15:8] + dev[7:0] + len + fmt + func;
        send_byte(HDR_BYTE);
        send_byte(dev[15:8]);
        send_byte(dev[7:0]);
        send_byte(len);
        send_byte(fmt);
        send_byte(func);
        for (i = 0; i < int'(len - BASE_LEN); i++)
        begin
            b   = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
            sum = sum + b;
            send_byte(b);
        end
        if (bad_sum)
            sum = sum + 8'($urandom_range(255, 1));
        send_byte(sum);
    endtask

    task automatic send_short(input logic [15:0] dev, input logic [7:0] len);
        send_byte(HDR_BYTE);
        send_byte(dev[15:8]);
        send_byte(dev[7:0]);
        send_byte(len);
    endtask

    task automatic wait_reports_clear();
        rx_valid <= 1'b0;
        while (frame_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // finish any half-received frame so the core is back to hunting, then write the device filter
    task automatic settle_and_set_filter(input logic [15:0] value);
        while (fr_phase != PH_HUNT)
            send_byte(8'h00);
        wait_reports_clear();
        cfg_valid     <= 1'b1;
        device_filter <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        filter_shadow = value;
    endtask

    task automatic send_random_frame();
        int          pick;
        logic [15:0] dev;
        logic [7:0]  len;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: dev = filter_shadow;
            1: dev = 16'($urandom_range(16'hFFFF));
            2: dev = 16'h0000;
            default: dev = 16'hFFFF;
        endcase
        if (pick < 8)
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
        else if (pick < 16)
            send_short(dev, 8'($urandom_range(5)));
        else if (pick < 22)
        begin
            // header followed by a truncated frame, then whatever comes next
            send_byte(HDR_BYTE);
            repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
        end
        else
        begin
            len = (pick < 26) ? 8'($urandom_range(60, 6)) : 8'($urandom_range(14, 6));
            send_frame(dev, len, 8'($urandom_range(255)), -1, $urandom_range(99) < 15);
        end
    endtask

    task automatic test_directed();
        settle_and_set_filter(ANY_DEVICE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h50);
        send_short(16'h0000, 8'd0);
        send_short(16'hFFFF, 8'd5);
        send_frame(16'hFFFF, 8'd6, 8'hFF, -1, 1'b0);
        send_frame(16'h0000, 8'd7, 8'h00, 255, 1'b1);
    endtask

    task automatic test_device_filter();
        settle_and_set_filter(16'h1234);
        send_frame(16'h1234, 8'd9, 8'h12, -1, 1'b0);
        send_frame(16'h1235, 8'd9, 8'h34, -1, 1'b0);
        send_frame(16'h1235, 8'd8, 8'h56, -1, 1'b1);
        send_frame(16'h1234, 8'd8, 8'h78, -1, 1'b1);
        settle_and_set_filter(16'hFFFF);
        send_frame(16'hFFFF, 8'd10, 8'h9A, -1, 1'b0);
        send_frame(16'h0000, 8'd10, 8'hBC, -1, 1'b0);
        send_short(16'h0001, 8'd3);
    endtask

    task automatic test_header_inside_frame();
        settle_and_set_filter(ANY_DEVICE);
        send_frame(16'h5151, HDR_BYTE, HDR_BYTE, int'(HDR_BYTE), 1'b0);
        send_short(16'h5151, 8'd1);
        send_frame(16'h0051, 8'd12, 8'h01, -1, 1'b0);
    endtask

    task automatic test_data_lengths();
        int n;
        settle_and_set_filter(ANY_DEVICE);
        for (n = 6; n <= 11; n++)
            send_frame(16'($urandom_range(16'hFFFF)), 8'(n), 8'($urandom_range(255)),
                       -1, 1'b0);
        send_frame(16'hA5A5, 8'd255, 8'h80, -1, 1'b0);
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input logic [15:0] filter_value, input int n_items);
        int target;
        settle_and_set_filter(filter_value);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = items_used + n_items;
        while (items_used < target)
            send_random_frame();
    endtask

    // result side held off long enough for the core to back up into its input
    task automatic test_result_hold_off();
        settle_and_set_filter(ANY_DEVICE);
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (10)
            send_frame(16'($urandom_range(16'hFFFF)), 8'd6, 8'($urandom_range(255)),
                       -1, 1'b0);
        wait_reports_clear();
    endtask

    initial
    begin : run_tests
        int guard;
        clear_frame_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_device_filter();
        test_header_inside_frame();
        test_data_lengths();
        test_result_hold_off();
        test_random_traffic(0, 0, ANY_DEVICE, 95);
        test_random_traffic(52, 0, 16'hFFFF, 95);
        test_random_traffic(0, 52, 16'($urandom_range(16'hFFFF, 1)), 95);
        test_random_traffic(33, 33, 16'h0001, 95);

        rx_valid <= 1'b0;
        guard = 0;
        while (frame_reports_due.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (frame_reports_due.size() != 0)
        begin
            $error("%0d frame reports never arrived", frame_reports_due.size());
            err_count++;
        end

        $display("covered %0d input bytes over idle/stall mixes, filter settings and a hold-off",
                 items_used);
        $display("reports: %0d accepted, %0d bad checksum, %0d other device, %0d malformed",
                 status_seen[ST_ACCEPTED], status_seen[ST_CHECKSUM],
                 status_seen[ST_OTHER_DEV], status_seen[ST_MALFORMED]);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
